// ===== rtl/sparse_patch_overlay_reader_unit_defines.svh =====
// Assertion macros shared by the sparse patch overlay reader checker
`ifndef SPARSE_PATCH_OVERLAY_READER_UNIT_DEFINES_SVH
`define SPARSE_PATCH_OVERLAY_READER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SPOR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPOR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spor_pkg.sv =====
// Package: types and constants of the sparse patch overlay reader
`timescale 1ns / 1ps
package spor_pkg;

    localparam int TEXT_DEPTH_DEF  = 65536;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_READ_DEF    = 64;
    localparam int CFG_W           = 17;
    localparam int POS_W           = 16;
    localparam int LEN_W           = 7;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_BYTE   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_SRCH,
        S_SRCH_CMP,
        S_RD,
        S_EMIT
    } t_state;

    // classified command handed from front to back
    typedef struct packed {
        t_req             req;
        logic [POS_W-1:0] pos;
        logic [7:0]       val;
        logic [LEN_W-1:0] len;   // clamped window length for reads
        logic             empty; // read yields a single empty result
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        logic [5:0] buffer_index;
        logic       last;
    } t_rsp;

endpackage

// ===== rtl/spor_req_if.sv =====
// Request channel interface
`timescale 1ns / 1ps
interface spor_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] position;
    logic [7:0]  byte_value;
    logic [6:0]  read_length;

    modport source (output valid, req_type, position, byte_value, read_length, input ready);
    modport sink   (input valid, req_type, position, byte_value, read_length, output ready);
endinterface

// ===== rtl/spor_rsp_if.sv =====
// Result channel interface
`timescale 1ns / 1ps
interface spor_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [5:0] buffer_index;
    logic       last;

    modport source (output valid, status, data_byte, buffer_index, last, input ready);
    modport sink   (input valid, status, data_byte, buffer_index, last, output ready);
endinterface

// ===== rtl/sparse_patch_overlay_reader_unit.sv =====
// Top level of the sparse patch overlay reader
`timescale 1ns / 1ps
// Flow: a write, append or clear goes from idle through the single-result state.
// A read runs binary-search steps over the substitution table (about log2(count)+1
// steps), each a table read then a compare, then a read and an emit per returned
// byte, since each byte needs a registered read of the base store and of the
// table's single read port. The two-entry command queue lets new requests be taken
// while the back end works; the output register lets it run ahead by one result.
module sparse_patch_overlay_reader_unit #(
    parameter int TEXT_DEPTH  = spor_pkg::TEXT_DEPTH_DEF,
    parameter int TABLE_DEPTH = spor_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_READ    = spor_pkg::MAX_READ_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spor_pkg::CFG_W-1:0] i_cfg_wdata,
    spor_req_if.sink                   i_req,
    spor_rsp_if.source                 o_rsp
);
    import spor_pkg::*;

    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;
    logic w_rsp_valid;
    logic w_rsp_ready;
    t_rsp w_rsp;

    spor_front #(
        .TEXT_DEPTH (TEXT_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .o_push_cmd   (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    spor_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_cmd   (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_cmd    (w_pop_cmd),
        .i_pop_ready  (w_pop_ready)
    );

    spor_back #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_cmd   (w_pop_cmd),
        .o_pop_ready (w_pop_ready),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp       (w_rsp),
        .i_rsp_ready (w_rsp_ready)
    );

    assign o_rsp.valid        = w_rsp_valid;
    assign o_rsp.status       = w_rsp.status;
    assign o_rsp.data_byte    = w_rsp.data_byte;
    assign o_rsp.buffer_index = w_rsp.buffer_index;
    assign o_rsp.last         = w_rsp.last;
    assign w_rsp_ready        = o_rsp.ready;

endmodule

// ===== rtl/spor_front.sv =====
// Front end: holds text length, classifies requests and clamps read windows
`timescale 1ns / 1ps
module spor_front #(
    parameter int TEXT_DEPTH = spor_pkg::TEXT_DEPTH_DEF,
    parameter int MAX_READ   = spor_pkg::MAX_READ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spor_pkg::CFG_W-1:0]  i_cfg_wdata,
    spor_req_if.sink                    i_req,
    output logic                        o_push_valid,
    output spor_pkg::t_cmd              o_push_cmd,
    input  logic                        i_push_ready
);
    import spor_pkg::*;

    localparam int AW  = $clog2(TEXT_DEPTH) + 1;
    localparam int TLW = (AW > CFG_W) ? AW : CFG_W;

    logic [CFG_W-1:0] r_text_len;
    logic [TLW-1:0]   w_tlen;
    logic [TLW-1:0]   w_pos;
    logic [LEN_W-1:0] w_len;
    logic [TLW-1:0]   w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_len <= '0;
        end else if (i_cfg_we) begin
            r_text_len <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_tlen = TLW'(r_text_len);
        if (w_tlen > TLW'(TEXT_DEPTH)) begin
            w_tlen = TLW'(TEXT_DEPTH);
        end
        w_pos = TLW'(i_req.position);
        w_len = i_req.read_length;
        if (w_len > LEN_W'(MAX_READ)) begin
            w_len = LEN_W'(MAX_READ);
        end
        w_end = w_pos + TLW'(w_len);
        if (w_end > w_tlen && w_pos < w_tlen) begin
            w_len = LEN_W'(w_tlen - w_pos);
        end

        o_push_cmd.req   = t_req'(i_req.req_type);
        o_push_cmd.pos   = i_req.position;
        o_push_cmd.val   = i_req.byte_value;
        o_push_cmd.len   = w_len;
        o_push_cmd.empty = (w_pos >= w_tlen) || (i_req.read_length == '0);
    end

    assign o_push_valid = i_req.valid;
    assign i_req.ready  = i_push_ready;

endmodule

// ===== rtl/spor_fifo.sv =====
// Two-entry command queue between front and back
`timescale 1ns / 1ps
module spor_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  spor_pkg::t_cmd i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output spor_pkg::t_cmd o_pop_cmd,
    input  logic           i_pop_ready
);
    import spor_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/spor_back.sv =====
// Back end: base store, substitution table, binary search and byte streaming
`timescale 1ns / 1ps
module spor_back #(
    parameter int TEXT_DEPTH  = spor_pkg::TEXT_DEPTH_DEF,
    parameter int TABLE_DEPTH = spor_pkg::TABLE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  spor_pkg::t_cmd i_pop_cmd,
    output logic           o_pop_ready,
    output logic           o_rsp_valid,
    output spor_pkg::t_rsp o_rsp,
    input  logic           i_rsp_ready
);
    import spor_pkg::*;

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0]       mem_base  [TEXT_DEPTH];
    logic [POS_W-1:0] mem_tpos  [TABLE_DEPTH];
    logic [7:0]       mem_tbyte [TABLE_DEPTH];

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [TW:0]      r_count, n_count;
    logic [POS_W-1:0] r_last_pos, n_last_pos;
    logic [TW:0]      r_lo, n_lo;
    logic [TW:0]      r_hi, n_hi;
    logic [TW:0]      r_j, n_j;
    logic [LEN_W-1:0] r_k, n_k;
    t_status          r_single, n_single;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic [7:0]       r_base_q;
    logic [POS_W-1:0] r_tpos_q;
    logic [7:0]       r_tbyte_q;

    logic             w_base_we;
    logic             w_tbl_we;
    logic [AW-1:0]    w_base_addr;
    logic [TW-1:0]    w_tbl_raddr;
    logic [TW:0]      w_mid;
    logic [POS_W:0]   w_cur;
    logic             w_out_free;
    logic             w_hit;

    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_cur       = (POS_W + 1)'(r_cmd.pos) + (POS_W + 1)'(r_k);
    assign w_hit       = (r_j < r_count) && ((POS_W + 1)'(r_tpos_q) == w_cur);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_last_pos  = r_last_pos;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_k         = r_k;
        n_single    = r_single;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_pop_ready = 1'b0;
        w_base_we   = 1'b0;
        w_tbl_we    = 1'b0;
        w_base_addr = AW'(i_pop_cmd.pos);
        w_tbl_raddr = r_j[TW-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_cmd    = i_pop_cmd;
                    n_single = ST_OK;
                    n_state  = S_SINGLE;
                    unique case (i_pop_cmd.req)
                        REQ_WRITE: begin
                            w_base_we = (32'(i_pop_cmd.pos) < 32'(TEXT_DEPTH));
                        end
                        REQ_APPEND: begin
                            if (32'(r_count) >= 32'(TABLE_DEPTH)) begin
                                n_single = ST_REJECT;
                            end else if (i_pop_cmd.pos <= r_last_pos) begin
                                n_single   = ST_REJECT;
                                n_count    = '0;
                                n_last_pos = '0;
                            end else begin
                                w_tbl_we   = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_last_pos = i_pop_cmd.pos;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count    = '0;
                            n_last_pos = '0;
                        end
                        REQ_READ: begin
                            if (i_pop_cmd.empty) begin
                                n_single = ST_EMPTY;
                            end else begin
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_k     = '0;
                                n_state = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_single;
                    n_out.data_byte    = '0;
                    n_out.buffer_index = '0;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    w_tbl_raddr = w_mid[TW-1:0];
                    n_state     = S_SRCH_CMP;
                end else begin
                    n_j     = r_lo;
                    n_state = S_RD;
                end
            end
            S_SRCH_CMP: begin
                if (r_tpos_q < r_cmd.pos) begin
                    n_lo = w_mid + 1'b1;
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SRCH;
            end
            S_RD: begin
                w_base_addr = AW'(w_cur);
                w_tbl_raddr = r_j[TW-1:0];
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // keep the base read on the current byte while the output stalls
                w_base_addr = AW'(w_cur);
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_BYTE;
                    n_out.data_byte    = w_hit ? r_tbyte_q : r_base_q;
                    n_out.buffer_index = r_k[5:0];
                    n_out.last         = (r_k + 1'b1 == r_cmd.len);
                    if (w_hit) begin
                        n_j = r_j + 1'b1;
                    end
                    n_k     = r_k + 1'b1;
                    n_state = (r_k + 1'b1 == r_cmd.len) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last_pos  <= n_last_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_j      <= n_j;
        r_k      <= n_k;
        r_single <= n_single;
        r_out    <= n_out;
    end

    // base store: one write port and one registered read port sharing one address
    always_ff @(posedge i_clk) begin
        if (w_base_we) begin
            mem_base[w_base_addr] <= i_pop_cmd.val;
        end
        r_base_q <= mem_base[w_base_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            mem_tpos[r_count[TW-1:0]]  <= i_pop_cmd.pos;
            mem_tbyte[r_count[TW-1:0]] <= i_pop_cmd.val;
        end
        r_tpos_q  <= mem_tpos[w_tbl_raddr];
        r_tbyte_q <= mem_tbyte[w_tbl_raddr];
    end

endmodule

// ===== rtl/spor_checker.sv =====
// Port-level checker for the sparse patch overlay reader, bound to the top level
`timescale 1ns / 1ps
`include "sparse_patch_overlay_reader_unit_defines.svh"
module spor_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_status,
    input logic [7:0] i_data_byte,
    input logic [5:0] i_buffer_index,
    input logic       i_last
);
    import spor_pkg::*;

    `SPOR_ASSERT_NEXT(a_hold_valid, i_valid && !i_ready, i_valid, "result dropped while stalled")
    `SPOR_ASSERT_NEXT(a_hold_data, i_valid && !i_ready, $stable(i_data_byte), "data moved while stalled")
    `SPOR_ASSERT_NOW(a_single_last, i_valid && i_status != ST_BYTE, i_last && i_data_byte == 8'd0, "non-byte result not single")
    `SPOR_ASSERT_NOW(a_empty_index, i_valid && i_status != ST_BYTE, i_buffer_index == 6'd0, "non-byte result has index")

endmodule

bind sparse_patch_overlay_reader_unit spor_checker u_spor_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_data_byte    (o_rsp.data_byte),
    .i_buffer_index (o_rsp.buffer_index),
    .i_last         (o_rsp.last)
);
